>>> design/hal_pkg.sv
// Shared types, codes and defaults for the hello adjacency liveness monitor.
// No dependencies; hal_ctrl, hal_dp and the top level import it.
`default_nettype none
package hal_pkg;

  localparam int NUM_FACES_DFLT = 16;

  localparam logic [7:0] MISS_THRESHOLD_DFLT = 8'd3;

  // commands
  localparam logic [1:0] CMD_ENABLE  = 2'd0;
  localparam logic [1:0] CMD_DISABLE = 2'd1;
  localparam logic [1:0] CMD_DATA    = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_HELLO  = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ALREADY_EN   = 2'd1;
  localparam logic [1:0] ST_ALREADY_DIS  = 2'd2;

  // register indexes
  localparam logic [7:0] REG_MISS_THRESHOLD   = 8'd0;
  localparam logic [7:0] REG_PROTOCOL_ENABLED = 8'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  face_id;
    logic [63:0] rx_seq;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  out_face;
    logic [63:0] tx_seq;
    logic        is_down;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_NONE,
    S_CMD,
    S_SCAN,
    S_READ,
    S_EVAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic emit_none;
    logic emit_cmd;
    logic emit_eval;
    logic scan_clr;
    logic scan_inc;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       proto_en;
    logic       any_active;
    logic       face_oor;
    logic       slot_active;
    logic       last_active;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/hal_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Depends on nothing; payload types come from hal_pkg at instantiation.
`default_nettype none
interface hal_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/hal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hal_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/hal_ctrl.sv
// Controller state machine: sequences decode, slot scan, RAM read and result emit.
// Depends on hal_pkg.
`default_nettype none
module hal_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hal_pkg::dp_stat_t  stat,
  output hal_pkg::ctrl_cmd_t      cmd
);
  import hal_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat.cmd == CMD_TICK) begin
          state_next = (stat.proto_en && stat.any_active) ? S_SCAN : S_NONE;
        end else if (stat.face_oor) begin
          state_next = S_NONE;
        end else if (stat.cmd == CMD_ENABLE || stat.cmd == CMD_DISABLE) begin
          state_next = S_CMD;
        end else begin
          state_next = stat.proto_en ? S_READ : S_NONE;
        end
      end
      S_NONE, S_CMD: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.slot_active) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.out_free) begin
          state_next = (stat.cmd == CMD_TICK && !stat.last_active) ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.emit_none = (state == S_NONE) && stat.out_free;
    cmd.emit_cmd  = (state == S_CMD) && stat.out_free;
    cmd.emit_eval = (state == S_EVAL) && stat.out_free;
    cmd.scan_clr  = (state == S_DECODE);
    cmd.scan_inc  = ((state == S_SCAN) && !stat.slot_active) ||
                    ((state == S_EVAL) && stat.out_free && stat.cmd == CMD_TICK);
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_none || cmd.emit_cmd || cmd.emit_eval) |-> stat.out_free)
    else $error("result emitted while output register busy");

  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_none, cmd.emit_cmd, cmd.emit_eval}))
    else $error("more than one emit in a cycle");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && $past(state) != S_EVAL) |-> $past(state) == S_READ)
    else $error("evaluation without a RAM read");

  a_scan_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_inc |-> stat.cmd == CMD_TICK)
    else $error("scan advanced outside a tick");

endmodule
`default_nettype wire

>>> design/hal_dp.sv
// Datapath: config registers, adjacency flags, sequence RAMs and output register.
// Depends on hal_pkg and hal_ram.
`default_nettype none
module hal_dp #(
  parameter int NUM_FACES = hal_pkg::NUM_FACES_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hal_pkg::item_t     item_data,
  input  wire logic               cfg_valid,
  input  wire hal_pkg::cfg_t      cfg_data,
  input  wire logic               result_ready,
  output logic                    result_valid,
  output hal_pkg::result_t        result_data,
  input  wire hal_pkg::ctrl_cmd_t cmd,
  output hal_pkg::dp_stat_t       stat
);
  import hal_pkg::*;

  localparam int IDX_W = (NUM_FACES > 1) ? $clog2(NUM_FACES) : 1;
  localparam int CNT_W = $clog2(NUM_FACES + 1);

  logic [7:0]           miss_threshold;
  logic                 protocol_enabled;
  logic [NUM_FACES-1:0] adj_active;
  logic [NUM_FACES-1:0] down_flag;
  logic [NUM_FACES-1:0] sent_vld;
  logic [NUM_FACES-1:0] acked_vld;
  logic [CNT_W-1:0]     active_count;
  item_t                item_q;
  logic [IDX_W-1:0]     scan_idx;

  logic [IDX_W-1:0]     face_idx;
  logic [IDX_W-1:0]     addr;
  logic                 is_tick;
  logic [63:0]          sent_raw, acked_raw, sent_rd, acked_rd;
  logic [63:0]          sent_inc, diff;
  logic                 miss_hit, rx_newer;
  logic [NUM_FACES-1:0] hi_mask;
  logic                 we_sent, we_acked;

  assign is_tick  = (item_q.command == CMD_TICK);
  assign face_idx = IDX_W'(item_q.face_id);
  assign addr     = is_tick ? scan_idx : face_idx;

  always_comb begin
    for (int i = 0; i < NUM_FACES; i++) begin
      hi_mask[i] = (i > int'(scan_idx));
    end
  end

  assign sent_rd  = sent_vld[addr] ? sent_raw : 64'd0;
  assign acked_rd = acked_vld[addr] ? acked_raw : 64'd0;
  assign diff     = sent_rd - acked_rd;
  assign sent_inc = sent_rd + 64'd1;
  assign miss_hit = (|diff[63:8]) || (diff[7:0] >= miss_threshold);
  assign rx_newer = (acked_rd < item_q.rx_seq);

  assign we_sent  = cmd.emit_eval && is_tick;
  assign we_acked = cmd.emit_eval && !is_tick && rx_newer;

  hal_ram #(.WIDTH(64), .DEPTH(NUM_FACES)) u_sent_ram (
    .clk   (clk),
    .we    (we_sent),
    .waddr (addr),
    .wdata (sent_inc),
    .raddr (addr),
    .rdata (sent_raw)
  );

  hal_ram #(.WIDTH(64), .DEPTH(NUM_FACES)) u_acked_ram (
    .clk   (clk),
    .we    (we_acked),
    .waddr (addr),
    .wdata (item_q.rx_seq),
    .raddr (addr),
    .rdata (acked_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_threshold   <= MISS_THRESHOLD_DFLT;
      protocol_enabled <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_data.index == REG_MISS_THRESHOLD) begin
        miss_threshold <= cfg_data.value;
      end else if (cfg_data.index == REG_PROTOCOL_ENABLED) begin
        protocol_enabled <= cfg_data.value[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_active   <= '0;
      down_flag    <= '0;
      sent_vld     <= '0;
      acked_vld    <= '0;
      active_count <= '0;
    end else begin
      if (we_sent) begin
        sent_vld[addr] <= 1'b1;
        if (miss_hit) down_flag[addr] <= 1'b1;
      end
      if (we_acked) begin
        acked_vld[addr] <= 1'b1;
        down_flag[addr] <= 1'b0;
      end
      if (cmd.emit_cmd) begin
        if (item_q.command == CMD_ENABLE && !adj_active[face_idx]) begin
          adj_active[face_idx] <= 1'b1;
          down_flag[face_idx]  <= 1'b1;
          active_count         <= active_count + CNT_W'(1);
        end else if (item_q.command == CMD_DISABLE && adj_active[face_idx]) begin
          adj_active[face_idx] <= 1'b0;
          down_flag[face_idx]  <= 1'b0;
          if (active_count != '0) active_count <= active_count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_none || cmd.emit_cmd || cmd.emit_eval) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_none) begin
      result_data <= '{kind: KIND_NONE, status: ST_OK, out_face: 4'd0,
                       tx_seq: 64'd0, is_down: 1'b0, last: 1'b1};
    end else if (cmd.emit_cmd) begin
      result_data.kind     <= KIND_STATUS;
      result_data.out_face <= item_q.face_id;
      result_data.tx_seq   <= 64'd0;
      result_data.last     <= 1'b1;
      if (item_q.command == CMD_ENABLE) begin
        result_data.status  <= adj_active[face_idx] ? ST_ALREADY_EN : ST_OK;
        result_data.is_down <= adj_active[face_idx] ? down_flag[face_idx] : 1'b1;
      end else begin
        result_data.status  <= adj_active[face_idx] ? ST_OK : ST_ALREADY_DIS;
        result_data.is_down <= adj_active[face_idx] ? 1'b0 : down_flag[face_idx];
      end
    end else if (cmd.emit_eval) begin
      result_data.status <= ST_OK;
      if (is_tick) begin
        result_data.kind     <= KIND_HELLO;
        result_data.out_face <= 4'(scan_idx);
        result_data.tx_seq   <= sent_inc;
        result_data.is_down  <= down_flag[addr] | miss_hit;
        result_data.last     <= ~|(adj_active & hi_mask);
      end else begin
        result_data.kind     <= KIND_DATA;
        result_data.out_face <= item_q.face_id;
        result_data.tx_seq   <= 64'd0;
        result_data.is_down  <= rx_newer ? 1'b0 : down_flag[addr];
        result_data.last     <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.cmd         = item_q.command;
    stat.proto_en    = protocol_enabled;
    stat.any_active  = (active_count != '0);
    stat.face_oor    = (32'(item_q.face_id) >= 32'(NUM_FACES));
    stat.slot_active = adj_active[scan_idx];
    stat.last_active = ~|(adj_active & hi_mask);
    stat.out_free    = !result_valid || result_ready;
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    active_count == CNT_W'($countones(adj_active)))
    else $error("active count out of step with active flags");

  a_down_on_enable: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_cmd && item_q.command == CMD_ENABLE && !adj_active[face_idx])
      |=> adj_active[$past(face_idx)] && down_flag[$past(face_idx)])
    else $error("enabled slot not marked active and down");

endmodule
`default_nettype wire

>>> design/hello_adjacency_liveness.sv
// Top level of the hello adjacency liveness monitor: controller plus datapath.
// Depends on hal_pkg, hal_chan_if, hal_ctrl, hal_dp (and hal_ram below it).
//
//   channel   dir   payload                                        beat when
//   item      in    command, face_id, rx_seq                       valid && ready
//   result    out   kind, status, out_face, tx_seq, is_down, last  valid && ready
//   cfg       in    index, value                                   valid (ready is 1)
//
// Enable/disable, out-of-range and dropped items pass through accept, decode and emit.
// Received data adds a RAM read of the acked number before evaluation. A tick takes accept
// and decode, then scans each slot up to the last active one, with a read and an evaluate
// step for each active slot; the read step is there because the RAM read is registered.
// Reset is synchronous; flags and the valid bits of the sequence RAMs clear at once.
// A result waiting in the output register stalls the walk; once an item's final result is
// registered, the next item is taken meanwhile.
`default_nettype none
module hello_adjacency_liveness #(
  parameter int NUM_FACES = hal_pkg::NUM_FACES_DFLT
) (
  input wire logic clk,
  input wire logic rst,
  hal_chan_if.sink   item,
  hal_chan_if.source result,
  hal_chan_if.sink   cfg
);
  import hal_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign item.ready = in_ready;
  assign cfg.ready  = 1'b1;

  hal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hal_dp #(.NUM_FACES(NUM_FACES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_data    (item.data),
    .cfg_valid    (cfg.valid),
    .cfg_data     (cfg.data),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .result_data  (result.data),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
`default_nettype wire
